// ===== src/lcdbc_pkg.sv =====
// Shared types, codes and helpers for the character LCD bus controller.
`default_nettype none

package lcdbc_pkg;

    // Request actions carried on the input tuser.
    localparam logic [2:0] ACT_DATA     = 3'd0;
    localparam logic [2:0] ACT_COMMAND  = 3'd1;
    localparam logic [2:0] ACT_SET_ADDR = 3'd2;
    localparam logic [2:0] ACT_CLEAR    = 3'd3;
    localparam logic [2:0] ACT_INIT     = 3'd4;
    localparam logic [2:0] ACT_STATUS   = 3'd5;

    // Result kinds carried on the output tuser.
    localparam logic [1:0] KIND_READ    = 2'd0;
    localparam logic [1:0] KIND_WRITE   = 2'd1;
    localparam logic [1:0] KIND_DELAY   = 2'd2;
    localparam logic [1:0] KIND_REFUSED = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_FOUR_BIT = 1'b0;
    localparam logic CFG_DUAL     = 1'b1;

    localparam logic [10:0] HOLD_US = 11'd1640;

    // Controller command bytes.
    localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
    localparam logic [7:0] CMD_FUNC_8BIT  = 8'h10;
    localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
    localparam logic [7:0] CMD_DISP_ON    = 8'h0c;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;

    // Init sequence steps; zero means no init running.
    localparam logic [2:0] STEP_IDLE  = 3'd0;
    localparam logic [2:0] STEP_FUNC  = 3'd1;
    localparam logic [2:0] STEP_OFF   = 3'd2;
    localparam logic [2:0] STEP_CLEAR = 3'd3;
    localparam logic [2:0] STEP_ON    = 3'd4;
    localparam logic [2:0] STEP_ENTRY = 3'd5;

    localparam int unsigned MAX_RESULTS = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic        target;
        logic        reg_select;
        logic        read_write;
        logic [7:0]  bus_value;
        logic [10:0] delay_after_us;
        logic        last;
    } result_t;

    // One processed request handed to the result buffer.
    typedef struct packed {
        logic                       valid;
        logic [2:0]                 count;
        result_t [MAX_RESULTS-1:0]  items;
    } push_t;

    function automatic logic [7:0] init_cmd(input logic [2:0] step, input logic four_bit);
        logic [7:0] b;
        unique case (step)
            STEP_FUNC:  b = four_bit ? CMD_FUNC_4BIT : (CMD_FUNC_4BIT | CMD_FUNC_8BIT);
            STEP_OFF:   b = CMD_DISP_OFF;
            STEP_CLEAR: b = CMD_CLEAR;
            STEP_ON:    b = CMD_DISP_ON;
            default:    b = CMD_ENTRY_MODE;
        endcase
        return b;
    endfunction

    function automatic result_t make_item(input logic [1:0] kind, input logic target,
                                          input logic rs, input logic rw,
                                          input logic [7:0] bus, input logic [10:0] dly);
        result_t r;
        r.kind           = kind;
        r.target         = target;
        r.reg_select     = rs;
        r.read_write     = rw;
        r.bus_value      = bus;
        r.delay_after_us = dly;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/char_lcd_bus_controller.sv =====
// Top level of the character LCD bus controller.
`default_nettype none

// Turns host requests (data, command, set address, clear, init) into the
// sequence of enable pulses for a character LCD controller bus. Each
// request starts a busy poll of two read pulses; the host answers with a
// status item carrying the busy flag, and the block either polls again or
// writes the byte (one pulse, or high then low nibble in 4-bit mode). Clear
// and the start of init carry a 1640 us hold; init walks the five setup
// commands on controller 0 and, in dual mode, on controller 1. A data,
// command, set address, clear or init request arriving while a transfer
// is pending is answered with one refused item. A request passes an input
// register, is resolved combinationally and lands in a four-entry result
// buffer that drains one item per cycle while m_tready is high. A request
// gives 0 to 4 items, and the next request is taken as the last of them is
// handed out. Configuration writes are taken in every cycle (cfg_ready is
// tied high) and belong in idle periods.
module char_lcd_bus_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Request channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // value[7:0], device[8], busy_req[9], zero[15:10]
    input  wire logic [2:0]  s_tuser,   // action[2:0]
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // target[0], reg_select[1], read_write[2],
                                        // bus_value[10:3], delay_after_us[21:11], zero[23:22]
    output logic [1:0]       m_tuser,   // kind[1:0]
    output logic             m_tlast,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data
);
    import lcdbc_pkg::*;

    push_t   push;
    logic    q_ready;
    result_t m_item;

    assign cfg_ready = 1'b1;

    // Resolve each request against the transfer state in a single pass.
    lcdbc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_ready   (q_ready),
        .push      (push)
    );

    // Hold the resulting bus items and hand them out one per handshake.
    lcdbc_resq u_resq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .q_ready  (q_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_item   (m_item)
    );

    assign m_tdata = {2'b00, m_item.delay_after_us, m_item.bus_value,
                      m_item.read_write, m_item.reg_select, m_item.target};
    assign m_tuser = m_item.kind;
    assign m_tlast = m_item.last;

endmodule

`default_nettype wire

// ===== src/lcdbc_core.sv =====
// Request register, transfer state and the per-request result logic.
`default_nettype none

module lcdbc_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [15:0]      s_tdata,
    input  wire logic [2:0]       s_tuser,
    input  wire logic             cfg_valid,
    input  wire logic             cfg_index,
    input  wire logic             cfg_data,
    input  wire logic             q_ready,
    output lcdbc_pkg::push_t      push
);
    import lcdbc_pkg::*;

    // Input register.
    logic       in_valid_reg;
    logic [2:0] in_action_reg;
    logic [7:0] in_value_reg;
    logic       in_device_reg;
    logic       in_busy_reg;

    // Configuration.
    logic four_bit_reg;
    logic dual_reg;

    // Transfer state.
    logic       pend_valid_reg, pend_valid_next;
    logic       pend_rs_reg, pend_rs_next;
    logic [7:0] pend_byte_reg, pend_byte_next;
    logic       pend_hold_reg, pend_hold_next;
    logic [2:0] step_reg, step_next;
    logic       itgt_reg, itgt_next;
    logic       adev_reg, adev_next;

    logic                      take;
    result_t [MAX_RESULTS-1:0] res_c;
    logic [2:0]                n;
    logic [2:0]                idx_last;
    logic                      line;
    logic [10:0]               dly;

    assign take     = in_valid_reg && q_ready;
    assign s_tready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_value_reg  <= s_tdata[7:0];
            in_device_reg <= s_tdata[8];
            in_busy_reg   <= s_tdata[9];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            four_bit_reg <= 1'b0;
            dual_reg     <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FOUR_BIT: four_bit_reg <= cfg_data;
                CFG_DUAL:     dual_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb begin
        res_c           = '0;
        n               = 3'd0;
        idx_last        = 3'd0;
        line            = 1'b0;
        dly             = 11'd0;
        pend_valid_next = pend_valid_reg;
        pend_rs_next    = pend_rs_reg;
        pend_byte_next  = pend_byte_reg;
        pend_hold_next  = pend_hold_reg;
        step_next       = step_reg;
        itgt_next       = itgt_reg;
        adev_next       = adev_reg;

        if (in_action_reg <= ACT_INIT) begin
            if (pend_valid_reg) begin
                res_c[0] = make_item(KIND_REFUSED, 1'b0, 1'b0, 1'b0, 8'h00, 11'd0);
                n        = 3'd1;
            end else begin
                pend_valid_next = 1'b1;
                if (in_action_reg == ACT_INIT) begin
                    step_next      = STEP_FUNC;
                    itgt_next      = 1'b0;
                    pend_rs_next   = 1'b0;
                    pend_byte_next = init_cmd(STEP_FUNC, four_bit_reg);
                    pend_hold_next = 1'b0;
                    adev_next      = 1'b0;
                    res_c[0] = make_item(KIND_DELAY, 1'b0, 1'b0, 1'b0, 8'h00, HOLD_US);
                    n        = 3'd1;
                end else begin
                    adev_next      = in_device_reg;
                    pend_rs_next   = (in_action_reg == ACT_DATA);
                    pend_hold_next = (in_action_reg == ACT_CLEAR);
                    priority if (in_action_reg == ACT_SET_ADDR) begin
                        pend_byte_next = CMD_SET_DDRAM | {1'b0, in_value_reg[6:0]};
                    end else if (in_action_reg == ACT_CLEAR) begin
                        pend_byte_next = CMD_CLEAR;
                    end else begin
                        pend_byte_next = in_value_reg;
                    end
                end
                // Busy poll: two read pulses on the instruction register.
                line = dual_reg && adev_next;
                res_c[n[1:0]]        = make_item(KIND_READ, line, 1'b0, 1'b1, 8'h00, 11'd0);
                res_c[n[1:0] + 2'd1] = make_item(KIND_READ, line, 1'b0, 1'b1, 8'h00, 11'd0);
                n = n + 3'd2;
            end
        end else if (in_action_reg == ACT_STATUS && pend_valid_reg) begin
            if (in_busy_reg) begin
                line     = dual_reg && adev_reg;
                res_c[0] = make_item(KIND_READ, line, 1'b0, 1'b1, 8'h00, 11'd0);
                res_c[1] = make_item(KIND_READ, line, 1'b0, 1'b1, 8'h00, 11'd0);
                n        = 3'd2;
            end else begin
                line = dual_reg && adev_reg;
                dly  = pend_hold_reg ? HOLD_US : 11'd0;
                if (four_bit_reg) begin
                    res_c[0] = make_item(KIND_WRITE, line, pend_rs_reg, 1'b0,
                                         {4'h0, pend_byte_reg[7:4]}, 11'd0);
                    res_c[1] = make_item(KIND_WRITE, line, pend_rs_reg, 1'b0,
                                         {4'h0, pend_byte_reg[3:0]}, dly);
                    n        = 3'd2;
                end else begin
                    res_c[0] = make_item(KIND_WRITE, line, pend_rs_reg, 1'b0,
                                         pend_byte_reg, dly);
                    n        = 3'd1;
                end
                pend_valid_next = 1'b0;
                if (step_reg != STEP_IDLE) begin
                    if (step_reg >= STEP_ENTRY) begin
                        if (dual_reg && !itgt_reg) begin
                            itgt_next = 1'b1;
                            step_next = STEP_FUNC;
                        end else begin
                            step_next = STEP_IDLE;
                            itgt_next = 1'b0;
                        end
                    end else begin
                        step_next = step_reg + 3'd1;
                    end
                    if (step_next != STEP_IDLE) begin
                        // Load the next init command and poll its controller.
                        pend_valid_next = 1'b1;
                        pend_rs_next    = 1'b0;
                        pend_byte_next  = init_cmd(step_next, four_bit_reg);
                        pend_hold_next  = (step_next == STEP_CLEAR);
                        adev_next       = itgt_next;
                        line            = dual_reg && itgt_next;
                        res_c[n[1:0]]        = make_item(KIND_READ, line, 1'b0, 1'b1,
                                                         8'h00, 11'd0);
                        res_c[n[1:0] + 2'd1] = make_item(KIND_READ, line, 1'b0, 1'b1,
                                                         8'h00, 11'd0);
                        n = n + 3'd2;
                    end
                end
            end
        end

        if (n != 3'd0) begin
            idx_last = n - 3'd1;
            res_c[idx_last[1:0]].last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            pend_rs_reg    <= 1'b0;
            pend_hold_reg  <= 1'b0;
            step_reg       <= STEP_IDLE;
            itgt_reg       <= 1'b0;
            adev_reg       <= 1'b0;
        end else if (take) begin
            pend_valid_reg <= pend_valid_next;
            pend_rs_reg    <= pend_rs_next;
            pend_hold_reg  <= pend_hold_next;
            step_reg       <= step_next;
            itgt_reg       <= itgt_next;
            adev_reg       <= adev_next;
        end
        if (take) begin
            pend_byte_reg <= pend_byte_next;
        end
    end

    assign push.valid = take;
    assign push.count = n;
    assign push.items = res_c;

endmodule

`default_nettype wire

// ===== src/lcdbc_resq.sv =====
// Result buffer: holds the items of one request and hands them out in order.
`default_nettype none

module lcdbc_resq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lcdbc_pkg::push_t  push,
    output logic                   q_ready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output lcdbc_pkg::result_t     m_item
);
    import lcdbc_pkg::*;

    result_t [MAX_RESULTS-1:0] slots_reg;
    logic [2:0]                rem_reg;
    logic [1:0]                idx_reg;
    logic                      pop;

    assign m_tvalid = (rem_reg != 3'd0);
    assign pop      = m_tvalid && m_tready;
    assign q_ready  = (rem_reg == 3'd0) || (rem_reg == 3'd1 && m_tready);
    assign m_item   = slots_reg[idx_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 3'd0;
            idx_reg <= 2'd0;
        end else if (push.valid && push.count != 3'd0) begin
            rem_reg <= push.count;
            idx_reg <= 2'd0;
        end else if (pop) begin
            rem_reg <= rem_reg - 3'd1;
            idx_reg <= idx_reg + 2'd1;
        end
        if (push.valid && push.count != 3'd0) begin
            slots_reg <= push.items;
        end
    end

endmodule

`default_nettype wire
